[rtl/mrrc_pkg.sv]
// Shared constants and types for the motor ramp and reversal controller.
package mrrc_pkg;

    localparam int LEVEL_BITS    = 8;
    localparam int THRESH_BITS   = 12;
    localparam int INTERVAL_BITS = 16;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;
    localparam int OUT_FIELD_BITS = 2 * LEVEL_BITS + 3;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [LEVEL_BITS-1:0] SPEED_MAX = 8'd255;

    localparam logic [REG_IDX_BITS-1:0] REG_LO_THRESH        = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_HI_THRESH        = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_TARGET_STEP      = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SLEW_STEP        = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_COMMAND_INTERVAL = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_RAMP_PERIOD      = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_REV_HOLD         = 3'd6;

    localparam logic [THRESH_BITS-1:0]   RST_LO_THRESH        = 12'd1000;
    localparam logic [THRESH_BITS-1:0]   RST_HI_THRESH        = 12'd3000;
    localparam logic [LEVEL_BITS-1:0]    RST_TARGET_STEP      = 8'd20;
    localparam logic [LEVEL_BITS-1:0]    RST_SLEW_STEP        = 8'd10;
    localparam logic [INTERVAL_BITS-1:0] RST_COMMAND_INTERVAL = 16'd150;
    localparam logic [INTERVAL_BITS-1:0] RST_RAMP_PERIOD      = 16'd40;
    localparam logic [INTERVAL_BITS-1:0] RST_REV_HOLD         = 16'd150;

    typedef struct packed {
        logic [THRESH_BITS-1:0]   lo_thresh;
        logic [THRESH_BITS-1:0]   hi_thresh;
        logic [LEVEL_BITS-1:0]    target_step;
        logic [LEVEL_BITS-1:0]    slew_step;
        logic [INTERVAL_BITS-1:0] command_interval;
        logic [INTERVAL_BITS-1:0] ramp_period;
        logic [INTERVAL_BITS-1:0] rev_hold;
    } cfg_t;

endpackage

[rtl/motor_ramp_reversal_controller.sv]
// Motor ramp and reversal controller: tick-driven duty ramp with paused reversal.
// An accepted item passes through the input register, then the result register, before m_tvalid rises.
// Throughput: one item per cycle while m_ is ready; each tick's update is one pass of compare-and-step logic.
// A stalled m_ leaves one item in each register, then s_tready drops until m_ drains.
// Reset (aresetn low, synchronous) restores register defaults, zero speed and target,
// clockwise direction, no pause, and cleared elapsed counters.
module motor_ramp_reversal_controller #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIMER_BITS  = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // tdata: x_sample, y_sample (lowest bits first), zero-filled to bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: duty[7:0], drive_clockwise[8], target_level[16:9],
    //        wanted_clockwise[17], pausing[18], zeros above
    output logic [mrrc_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mrrc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [mrrc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [mrrc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);
    import mrrc_pkg::*;

    localparam int SCMP_W = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
    localparam int TCMP_W = (TIMER_BITS > INTERVAL_BITS) ? TIMER_BITS : INTERVAL_BITS;

    cfg_t cfg_reg;

    logic [SAMPLE_BITS-1:0] x_reg;
    logic [SAMPLE_BITS-1:0] y_reg;
    logic                   in_valid_reg;

    logic [LEVEL_BITS-1:0]  target_reg, target_next;
    logic [LEVEL_BITS-1:0]  speed_reg, speed_next;
    logic                   want_cw_reg, want_cw_next;
    logic                   is_cw_reg, is_cw_next;
    logic                   pause_reg, pause_next;
    logic [TIMER_BITS-1:0]  since_cmd_reg, since_cmd_next;
    logic [TIMER_BITS-1:0]  since_ramp_reg, since_ramp_next;
    logic [TIMER_BITS-1:0]  since_pause_reg, since_pause_next;

    logic [OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                     m_valid_reg;

    logic advance;
    logic cfg_wr;
    logic [REG_IDX_BITS-1:0] reg_idx;

    logic [TIMER_BITS-1:0] cmd_tick, ramp_tick, pause_tick;
    logic                  cmd_due, ramp_due, pause_done;
    logic                  y_low, y_high;
    logic [LEVEL_BITS:0]   target_sum;
    logic [LEVEL_BITS-1:0] speed_slew, speed_down;

    function automatic logic [LEVEL_BITS-1:0] move_toward(
        input logic [LEVEL_BITS-1:0] cur,
        input logic [LEVEL_BITS-1:0] goal,
        input logic [LEVEL_BITS-1:0] step
    );
        logic [LEVEL_BITS-1:0] res;
        res = cur;
        if (cur < goal) begin
            res = ((goal - cur) > step) ? cur + step : goal;
        end else if (cur > goal) begin
            res = ((cur - goal) > step) ? cur - step : goal;
        end
        return res;
    endfunction

    function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // Handshake: input register drains whenever the result register can take a new value
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            REG_LO_THRESH:        prdata = APB_DATA_BITS'(cfg_reg.lo_thresh);
            REG_HI_THRESH:        prdata = APB_DATA_BITS'(cfg_reg.hi_thresh);
            REG_TARGET_STEP:      prdata = APB_DATA_BITS'(cfg_reg.target_step);
            REG_SLEW_STEP:        prdata = APB_DATA_BITS'(cfg_reg.slew_step);
            REG_COMMAND_INTERVAL: prdata = APB_DATA_BITS'(cfg_reg.command_interval);
            REG_RAMP_PERIOD:      prdata = APB_DATA_BITS'(cfg_reg.ramp_period);
            REG_REV_HOLD:         prdata = APB_DATA_BITS'(cfg_reg.rev_hold);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lo_thresh        <= RST_LO_THRESH;
            cfg_reg.hi_thresh        <= RST_HI_THRESH;
            cfg_reg.target_step      <= RST_TARGET_STEP;
            cfg_reg.slew_step        <= RST_SLEW_STEP;
            cfg_reg.command_interval <= RST_COMMAND_INTERVAL;
            cfg_reg.ramp_period      <= RST_RAMP_PERIOD;
            cfg_reg.rev_hold         <= RST_REV_HOLD;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LO_THRESH:        cfg_reg.lo_thresh        <= pwdata[THRESH_BITS-1:0];
                REG_HI_THRESH:        cfg_reg.hi_thresh        <= pwdata[THRESH_BITS-1:0];
                REG_TARGET_STEP:      cfg_reg.target_step      <= pwdata[LEVEL_BITS-1:0];
                REG_SLEW_STEP:        cfg_reg.slew_step        <= pwdata[LEVEL_BITS-1:0];
                REG_COMMAND_INTERVAL: cfg_reg.command_interval <= pwdata[INTERVAL_BITS-1:0];
                REG_RAMP_PERIOD:      cfg_reg.ramp_period      <= pwdata[INTERVAL_BITS-1:0];
                REG_REV_HOLD:         cfg_reg.rev_hold         <= pwdata[INTERVAL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Per-tick update
    always_comb begin
        cmd_tick   = tick_up(since_cmd_reg);
        ramp_tick  = tick_up(since_ramp_reg);
        pause_tick = tick_up(since_pause_reg);

        cmd_due    = TCMP_W'(cmd_tick)   >= TCMP_W'(cfg_reg.command_interval);
        ramp_due   = TCMP_W'(ramp_tick)  >= TCMP_W'(cfg_reg.ramp_period);
        pause_done = TCMP_W'(pause_tick) >= TCMP_W'(cfg_reg.rev_hold);

        want_cw_next = want_cw_reg;
        if (SCMP_W'(x_reg) < SCMP_W'(cfg_reg.lo_thresh)) begin
            want_cw_next = 1'b0;
        end else if (SCMP_W'(x_reg) > SCMP_W'(cfg_reg.hi_thresh)) begin
            want_cw_next = 1'b1;
        end

        y_low  = SCMP_W'(y_reg) < SCMP_W'(cfg_reg.lo_thresh);
        y_high = SCMP_W'(y_reg) > SCMP_W'(cfg_reg.hi_thresh);

        target_sum     = {1'b0, target_reg} + {1'b0, cfg_reg.target_step};
        target_next    = target_reg;
        since_cmd_next = cmd_tick;
        if (cmd_due) begin
            if (y_low) begin
                target_next    = (target_sum > {1'b0, SPEED_MAX}) ? SPEED_MAX
                                                                  : target_sum[LEVEL_BITS-1:0];
                since_cmd_next = '0;
            end else if (y_high) begin
                target_next    = (target_reg > cfg_reg.target_step)
                                 ? target_reg - cfg_reg.target_step : '0;
                since_cmd_next = '0;
            end
        end

        speed_down = move_toward(speed_reg, '0, cfg_reg.slew_step);
        speed_slew = move_toward(speed_reg, target_next, cfg_reg.slew_step);

        speed_next       = speed_reg;
        is_cw_next       = is_cw_reg;
        pause_next       = pause_reg;
        since_ramp_next  = ramp_tick;
        since_pause_next = pause_tick;
        if (ramp_due) begin
            since_ramp_next = '0;
            if (want_cw_next != is_cw_reg) begin
                priority if (speed_reg != '0) begin
                    speed_next = speed_down;
                end else if (!pause_reg) begin
                    since_pause_next = '0;
                    pause_next       = 1'b1;
                end else if (pause_done) begin
                    is_cw_next = want_cw_next;
                    pause_next = 1'b0;
                end else begin
                    pause_next = pause_reg;
                end
            end else begin
                pause_next = 1'b0;
                speed_next = speed_slew;
            end
        end

        m_tdata_next = OUT_DATA_BITS'({pause_next, want_cw_next, target_next,
                                       is_cw_next, speed_next});
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x_reg <= s_tdata[SAMPLE_BITS-1:0];
            y_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            target_reg      <= '0;
            speed_reg       <= '0;
            want_cw_reg     <= 1'b1;
            is_cw_reg       <= 1'b1;
            pause_reg       <= 1'b0;
            since_cmd_reg   <= '0;
            since_ramp_reg  <= '0;
            since_pause_reg <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance) begin
                target_reg      <= target_next;
                speed_reg       <= speed_next;
                want_cw_reg     <= want_cw_next;
                is_cw_reg       <= is_cw_next;
                pause_reg       <= pause_next;
                since_cmd_reg   <= since_cmd_next;
                since_ramp_reg  <= since_ramp_next;
                since_pause_reg <= since_pause_next;
            end
        end
    end

endmodule

[tb/motor_ramp_reversal_controller_tb.sv]
// Self-checking testbench for the motor ramp and reversal controller.
`timescale 1ns / 1ps

module motor_ramp_reversal_controller_tb;
    import mrrc_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int IN_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_TICKS = 70;
    localparam int B2B_TICKS   = 40;
    localparam int ERR_PRINTS  = 40;

    typedef struct packed {
        logic                  pausing;
        logic                  wanted_cw;
        logic [LEVEL_BITS-1:0] target_level;
        logic                  drive_cw;
        logic [LEVEL_BITS-1:0] duty;
    } motor_status_t;

    localparam int STATUS_BITS = $bits(motor_status_t);
    localparam int PAD_BITS    = OUT_DATA_BITS - STATUS_BITS;

    typedef enum logic { ROW_TICK, ROW_WRITE } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic                      checked;
        logic [REG_IDX_BITS-1:0]   reg_idx;
        logic [APB_DATA_BITS-1:0]  value;
        logic [SAMPLE_BITS-1:0]    x;
        logic [SAMPLE_BITS-1:0]    y;
        motor_status_t             fixed;
    } plan_row_t;

    logic                      aclk;
    logic                      aresetn;
    // tdata: x_sample[11:0], y_sample[23:12]
    logic [IN_BITS-1:0]        s_tdata;
    logic                      s_tvalid;
    logic                      s_tready;
    // tdata: duty[7:0], drive_clockwise[8], target_level[16:9],
    //        wanted_clockwise[17], pausing[18], zeros above
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_BITS-1:0]  paddr;
    logic [APB_DATA_BITS-1:0]  pwdata;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    motor_ramp_reversal_controller i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predicted controller state
    cfg_t                     pred_cfg;
    logic [LEVEL_BITS-1:0]    tgt;
    logic [LEVEL_BITS-1:0]    spd;
    logic                     want_cw;
    logic                     is_cw;
    logic                     pause_on;
    logic [INTERVAL_BITS-1:0] since_cmd;
    logic [INTERVAL_BITS-1:0] since_ramp;
    logic [INTERVAL_BITS-1:0] since_pause;

    motor_status_t status_q[$];
    plan_row_t     plan[$];
    motor_status_t want_st;
    motor_status_t got_st;
    int            errors;
    int            burst_left;
    bit            no_idle;
    bit            hold_req;

    function automatic logic [INTERVAL_BITS-1:0] sat_inc(logic [INTERVAL_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic logic [LEVEL_BITS-1:0] slew(logic [LEVEL_BITS-1:0] cur,
                                                   logic [LEVEL_BITS-1:0] goal,
                                                   logic [LEVEL_BITS-1:0] step);
        int c;
        int g;
        int s;
        c = cur;
        g = goal;
        s = step;
        if (c < g) return LEVEL_BITS'((g - c > s) ? c + s : g);
        if (c > g) return LEVEL_BITS'((c - g > s) ? c - s : g);
        return cur;
    endfunction

    function automatic motor_status_t ramp_tick(logic [SAMPLE_BITS-1:0] x,
                                                logic [SAMPLE_BITS-1:0] y);
        motor_status_t r;
        since_cmd   = sat_inc(since_cmd);
        since_ramp  = sat_inc(since_ramp);
        since_pause = sat_inc(since_pause);

        if (x < pred_cfg.lo_thresh) want_cw = 1'b0;
        else if (x > pred_cfg.hi_thresh) want_cw = 1'b1;

        if (since_cmd >= pred_cfg.command_interval) begin
            if (y < pred_cfg.lo_thresh) begin
                tgt = slew(tgt, SPEED_MAX, pred_cfg.target_step);
                since_cmd = '0;
            end else if (y > pred_cfg.hi_thresh) begin
                tgt = slew(tgt, '0, pred_cfg.target_step);
                since_cmd = '0;
            end
        end

        if (since_ramp >= pred_cfg.ramp_period) begin
            since_ramp = '0;
            if (want_cw != is_cw) begin
                if (spd != 0) begin
                    spd = slew(spd, '0, pred_cfg.slew_step);
                end else if (!pause_on) begin
                    since_pause = '0;
                    pause_on = 1'b1;
                end else if (since_pause >= pred_cfg.rev_hold) begin
                    is_cw = want_cw;
                    pause_on = 1'b0;
                end
            end else begin
                pause_on = 1'b0;
                spd = slew(spd, tgt, pred_cfg.slew_step);
            end
        end

        r.duty         = spd;
        r.drive_cw     = is_cw;
        r.target_level = tgt;
        r.wanted_cw    = want_cw;
        r.pausing      = pause_on;
        return r;
    endfunction

    function automatic plan_row_t tick_row(int x, int y);
        plan_row_t r;
        r = '0;
        r.kind = ROW_TICK;
        r.x = SAMPLE_BITS'(x);
        r.y = SAMPLE_BITS'(y);
        return r;
    endfunction

    function automatic plan_row_t check_row(int x, int y, int duty, int dcw, int target,
                                            int wcw, int pausing);
        plan_row_t r;
        r = tick_row(x, y);
        r.checked = 1'b1;
        r.fixed.duty = LEVEL_BITS'(duty);
        r.fixed.drive_cw = (dcw != 0);
        r.fixed.target_level = LEVEL_BITS'(target);
        r.fixed.wanted_cw = (wcw != 0);
        r.fixed.pausing = (pausing != 0);
        return r;
    endfunction

    function automatic plan_row_t write_row(logic [REG_IDX_BITS-1:0] idx,
                                            logic [APB_DATA_BITS-1:0] value);
        plan_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.value = value;
        return r;
    endfunction

    // region: 0 below low, 1 between, 2 above high, else anywhere
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(int region);
        int lo;
        int hi;
        lo = pred_cfg.lo_thresh;
        hi = pred_cfg.hi_thresh;
        case (region)
            0: return SAMPLE_BITS'((lo == 0) ? 0 : $urandom_range(lo - 1, 0));
            1: return SAMPLE_BITS'((lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(lo, hi));
            2: return SAMPLE_BITS'((hi == 4095) ? 4095 : $urandom_range(4095, hi + 1));
            default: return SAMPLE_BITS'($urandom_range(4095, 0));
        endcase
    endfunction

    task automatic send_item(input logic [SAMPLE_BITS-1:0] x, input logic [SAMPLE_BITS-1:0] y,
                             input bit checked, input motor_status_t fixed);
        motor_status_t p;
        s_tdata  <= {y, x};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = ramp_tick(x, y);
        status_q.push_back(checked ? fixed : p);
        @(negedge aclk);
    endtask

    task automatic offer(input logic [SAMPLE_BITS-1:0] x, input logic [SAMPLE_BITS-1:0] y,
                         input bit checked, input motor_status_t fixed);
        int gap;
        if (burst_left == 0 && !no_idle) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(24, 1);
        end
        if (burst_left > 0) burst_left--;
        send_item(x, y, checked, fixed);
    endtask

    // stop offering until every predicted status has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] value);
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_LO_THRESH:        pred_cfg.lo_thresh        = value[THRESH_BITS-1:0];
            REG_HI_THRESH:        pred_cfg.hi_thresh        = value[THRESH_BITS-1:0];
            REG_TARGET_STEP:      pred_cfg.target_step      = value[LEVEL_BITS-1:0];
            REG_SLEW_STEP:        pred_cfg.slew_step        = value[LEVEL_BITS-1:0];
            REG_COMMAND_INTERVAL: pred_cfg.command_interval = value[INTERVAL_BITS-1:0];
            REG_RAMP_PERIOD:      pred_cfg.ramp_period      = value[INTERVAL_BITS-1:0];
            REG_REV_HOLD:         pred_cfg.rev_hold         = value[INTERVAL_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        drain();
        repeat (4) @(negedge aclk);
    endtask

    // random setup; junk goes into the unused upper bits of every write
    task automatic random_setup();
        int v;
        case ($urandom_range(9, 0))
            0: v = 0;
            1: v = 4095;
            2: v = $urandom_range(4095, 0);
            default: v = $urandom_range(1400, 600);
        endcase
        cfg_write(REG_LO_THRESH, ($urandom() << THRESH_BITS) | v);
        case ($urandom_range(9, 0))
            0: v = 4095;
            1: v = 0;
            2: v = $urandom_range(4095, 0);
            default: v = $urandom_range(3400, 2600);
        endcase
        cfg_write(REG_HI_THRESH, ($urandom() << THRESH_BITS) | v);
        case ($urandom_range(7, 0))
            0: v = 0;
            1: v = 255;
            default: v = $urandom_range(60, 1);
        endcase
        cfg_write(REG_TARGET_STEP, ($urandom() << LEVEL_BITS) | v);
        case ($urandom_range(11, 0))
            0: v = 0;
            1: v = 255;
            default: v = $urandom_range(40, 1);
        endcase
        cfg_write(REG_SLEW_STEP, ($urandom() << LEVEL_BITS) | v);
        v = ($urandom_range(5, 0) == 0) ? $urandom_range(300, 20) : $urandom_range(12, 0);
        cfg_write(REG_COMMAND_INTERVAL, ($urandom() << INTERVAL_BITS) | v);
        v = ($urandom_range(5, 0) == 0) ? $urandom_range(300, 20) : $urandom_range(12, 0);
        cfg_write(REG_RAMP_PERIOD, ($urandom() << INTERVAL_BITS) | v);
        v = ($urandom_range(5, 0) == 0) ? $urandom_range(300, 20) : $urandom_range(12, 0);
        cfg_write(REG_REV_HOLD, ($urandom() << INTERVAL_BITS) | v);
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int rx_mode;
        int rx_cnt;
        int hold_left;
        rx_mode   = 0;
        rx_cnt    = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            rx_cnt++;
            if (rx_cnt % 64 == 0) rx_mode = $urandom_range(3, 0);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(3, 0) != 0);
                    2: m_tready <= (rx_cnt % 5 < 3);
                    default: m_tready <= ($urandom_range(1, 0) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_st = m_tdata[STATUS_BITS-1:0];
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= ERR_PRINTS)
                    $display("%0t: unexpected item on m_, tdata %h", $time, m_tdata);
            end else begin
                want_st = status_q.pop_front();
                if (m_tdata !== {{PAD_BITS{1'b0}}, want_st}) begin
                    errors++;
                    if (errors <= ERR_PRINTS)
                        $display({"%0t: status mismatch, expected duty=%0d cw=%0b target=%0d ",
                                  "want_cw=%0b pausing=%0b, got duty=%0d cw=%0b target=%0d ",
                                  "want_cw=%0b pausing=%0b (tdata %h)"},
                                 $time, want_st.duty, want_st.drive_cw, want_st.target_level,
                                 want_st.wanted_cw, want_st.pausing, got_st.duty,
                                 got_st.drive_cw, got_st.target_level, got_st.wanted_cw,
                                 got_st.pausing, m_tdata);
                end
            end
        end
    end

    initial begin
        int x_region;
        int x_run;
        int r;
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;

        aresetn    = 1'b0;
        s_tdata    = '0;
        s_tvalid   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        errors     = 0;
        burst_left = 0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        x_region   = 1;
        x_run      = 0;

        pred_cfg.lo_thresh        = RST_LO_THRESH;
        pred_cfg.hi_thresh        = RST_HI_THRESH;
        pred_cfg.target_step      = RST_TARGET_STEP;
        pred_cfg.slew_step        = RST_SLEW_STEP;
        pred_cfg.command_interval = RST_COMMAND_INTERVAL;
        pred_cfg.ramp_period      = RST_RAMP_PERIOD;
        pred_cfg.rev_hold         = RST_REV_HOLD;
        tgt         = '0;
        spd         = '0;
        want_cw     = 1'b1;
        is_cw       = 1'b1;
        pause_on    = 1'b0;
        since_cmd   = '0;
        since_ramp  = '0;
        since_pause = '0;

        // defaults: thresholds exact and either side, nothing due yet
        plan.push_back(check_row(0, 0, 0, 1, 0, 0, 0));
        plan.push_back(check_row(4095, 4095, 0, 1, 0, 1, 0));
        plan.push_back(check_row(1000, 1000, 0, 1, 0, 1, 0));
        plan.push_back(check_row(3000, 3000, 0, 1, 0, 1, 0));
        plan.push_back(check_row(999, 2000, 0, 1, 0, 0, 0));
        plan.push_back(check_row(3001, 2000, 0, 1, 0, 1, 0));
        // zero intervals, full steps
        plan.push_back(write_row(REG_COMMAND_INTERVAL, 0));
        plan.push_back(write_row(REG_RAMP_PERIOD, 0));
        plan.push_back(write_row(REG_TARGET_STEP, 255));
        plan.push_back(write_row(REG_SLEW_STEP, 255));
        plan.push_back(check_row(2048, 0, 255, 1, 255, 1, 0));
        plan.push_back(check_row(2048, 4095, 0, 1, 0, 1, 0));
        // zero ramp step: duty stuck, reversal parks in the pause
        plan.push_back(write_row(REG_TARGET_STEP, 20));
        plan.push_back(write_row(REG_SLEW_STEP, 0));
        plan.push_back(check_row(2048, 0, 0, 1, 20, 1, 0));
        plan.push_back(check_row(0, 2048, 0, 1, 20, 0, 1));
        plan.push_back(check_row(0, 2048, 0, 1, 20, 0, 1));
        plan.push_back(write_row(REG_REV_HOLD, 0));
        plan.push_back(write_row(REG_SLEW_STEP, 1));
        plan.push_back(check_row(0, 2048, 0, 0, 20, 0, 0));
        plan.push_back(check_row(2048, 0, 1, 0, 40, 0, 0));
        plan.push_back(check_row(4095, 2048, 0, 0, 40, 1, 0));
        plan.push_back(check_row(4095, 2048, 0, 0, 40, 1, 1));
        plan.push_back(check_row(4095, 2048, 0, 1, 40, 1, 0));
        // overlapping thresholds: low test wins
        plan.push_back(write_row(REG_LO_THRESH, 3000));
        plan.push_back(write_row(REG_HI_THRESH, 1000));
        plan.push_back(check_row(2000, 2000, 0, 1, 60, 0, 1));
        plan.push_back(check_row(2000, 4095, 0, 0, 40, 0, 0));
        // thresholds at the ends: no sample gets past either
        plan.push_back(write_row(REG_LO_THRESH, 0));
        plan.push_back(write_row(REG_HI_THRESH, 4095));
        plan.push_back(check_row(0, 0, 1, 0, 40, 0, 0));
        plan.push_back(check_row(4095, 4095, 2, 0, 40, 0, 0));
        // upper register bits ignored
        plan.push_back(write_row(REG_SLEW_STEP, 32'hFFFF_FF05));
        plan.push_back(write_row(REG_LO_THRESH, 32'hABCD_E3E8));
        plan.push_back(write_row(REG_HI_THRESH, 32'h5555_5BB8));
        plan.push_back(write_row(REG_COMMAND_INTERVAL, 32'h1234_0003));
        plan.push_back(write_row(REG_RAMP_PERIOD, 2));
        plan.push_back(write_row(REG_REV_HOLD, 65535));
        plan.push_back(tick_row(2048, 0));
        plan.push_back(tick_row(2048, 0));
        plan.push_back(tick_row(2048, 2048));
        plan.push_back(tick_row(0, 4095));
        plan.push_back(tick_row(0, 0));
        plan.push_back(tick_row(2730, 1365));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                cfg_write(plan[i].reg_idx, plan[i].value);
            end else begin
                offer(plan[i].x, plan[i].y, plan[i].checked, plan[i].fixed);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            random_setup();
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (ph == 5 && n == 40) drain();
                // direction requests come in runs so reversals can finish
                if (x_run == 0) begin
                    x_region = $urandom_range(2, 0);
                    x_run = $urandom_range(60, 5);
                end
                x_run--;
                x = ($urandom_range(9, 0) == 0) ? pick_sample(3) : pick_sample(x_region);
                r = $urandom_range(19, 0);
                if (r < 7) y = pick_sample(0);
                else if (r < 12) y = pick_sample(2);
                else if (r < 18) y = pick_sample(1);
                else y = pick_sample(3);
                offer(x, y, 1'b0, '0);
            end
        end

        // back-to-back run with the receiver always ready
        settle();
        cfg_write(REG_LO_THRESH, 1000);
        cfg_write(REG_HI_THRESH, 3000);
        cfg_write(REG_TARGET_STEP, 7);
        cfg_write(REG_SLEW_STEP, 3);
        cfg_write(REG_COMMAND_INTERVAL, 2);
        cfg_write(REG_RAMP_PERIOD, 1);
        cfg_write(REG_REV_HOLD, 3);
        no_idle = 1'b1;
        for (int n = 0; n < B2B_TICKS; n++) begin
            if (n < B2B_TICKS / 2) offer(12'd2048, 12'd0, 1'b0, '0);
            else offer(12'd0, 12'd4095, 1'b0, '0);
        end
        no_idle = 1'b0;

        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[motor_ramp_reversal_controller.f]
rtl/mrrc_pkg.sv
rtl/motor_ramp_reversal_controller.sv
tb/motor_ramp_reversal_controller_tb.sv
